/* design/distance_constraint_projection_top_defines.svh */
// Assertion macros for the distance constraint projection block
`ifndef DISTANCE_CONSTRAINT_PROJECTION_TOP_DEFINES_SVH
`define DISTANCE_CONSTRAINT_PROJECTION_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define DCP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dcp check failed");
// Next-cycle implication
`define DCP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dcp check failed");
`else
`define DCP_ASSERT_NOW(label, clk, rst, ante, cons)
`define DCP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* design/dcp_pkg.sv */
package dcp_pkg;

  // Result bits of the square root and of each quotient
  localparam int RT_BITS  = 33;
  localparam int DIV_BITS = 33;

  // Pipeline stage indexes
  localparam int ST_IN      = 0;
  localparam int ST_SQ_PART = 1;
  localparam int ST_SQ      = 2;
  localparam int ST_SUM     = 3;
  localparam int ST_RT0     = 4;
  localparam int ST_EXC     = ST_RT0 + RT_BITS;
  localparam int ST_PPART   = ST_EXC + 1;
  localparam int ST_PROD    = ST_PPART + 1;
  localparam int ST_DIV0    = ST_PROD + 1;
  localparam int ST_LAST    = ST_DIV0 + DIV_BITS - 1;

  typedef struct packed {
    logic [2:0][31:0] a;
    logic [2:0][31:0] b;
    logic [30:0]      rest;
    logic             fa;
    logic             fb;
  } item_t;

  typedef struct packed {
    item_t            it;
    logic [2:0][32:0] dm;
    logic [2:0]       dneg;
    logic [2:0][65:0] acc;
    logic [2:0][48:0] hi;
    logic [65:0]      rad;
    logic [32:0]      root;
    logic [32:0]      em;
    logic             eneg;
    logic             degen;
    logic [2:0][32:0] rem;
    logic [2:0][32:0] quo;
  } pipe_t;

  // Clamp a 35 bit signed sum to the 32 bit signed range
  function automatic logic [31:0] sat35(logic [34:0] v);
    logic [31:0] r;
    if (!v[34] && (v[33:31] != 3'b000)) begin
      r = 32'h7FFF_FFFF;
    end else if (v[34] && (v[33:31] != 3'b111)) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* design/distance_constraint_projection_top.sv */
// Channel  Handshake            Payload
// s        s_tvalid/s_tready    s_tdata: positions, rest length; s_tuser: fixed marks
// m        m_tvalid/m_tready    m_tdata: corrected positions; m_tuser: degenerate
//
// One item per cycle sustained while m is not stalled.
// The length of the pipeline is set mostly by the 33 stage square root and the
// 33 stage divider, one result bit per stage, the divider doing three axes side by side.
// Reset (rst, synchronous) clears all valid bits, the skid slot and m_tvalid.
// A stall at m holds the whole pipeline; one input skid slot keeps s_tready
// registered, so an item offered during a stall is taken and held.
`include "distance_constraint_projection_top_defines.svh"

module distance_constraint_projection_top
  import dcp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, rest length, pad
  input  logic [223:0] s_tdata,
  // first_fixed, second_fixed
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // new_first_x/y/z, new_second_x/y/z
  output logic [191:0] m_tdata,
  // degenerate
  output logic [0:0]   m_tuser
);

  logic                 en;
  logic                 in_take;
  logic                 skid_valid;
  item_t                skid;
  item_t                src;
  logic                 src_valid;
  pipe_t                p      [ST_LAST+1];
  pipe_t                p_next [ST_LAST+1];
  logic [ST_LAST:0]     v;
  logic [191:0]         res_data;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = !skid_valid;
  assign in_take  = s_tvalid && s_tready;

  // Pick the held item first, else the one on the port
  always_comb begin
    if (skid_valid) begin
      src = skid;
    end else begin
      src.a[0] = s_tdata[31:0];
      src.a[1] = s_tdata[63:32];
      src.a[2] = s_tdata[95:64];
      src.b[0] = s_tdata[127:96];
      src.b[1] = s_tdata[159:128];
      src.b[2] = s_tdata[191:160];
      src.rest = s_tdata[222:192];
      src.fa   = s_tuser[0];
      src.fb   = s_tuser[1];
    end
  end
  assign src_valid = skid_valid || in_take;

  // Hold an item that arrives during a stall
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (in_take) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_take) begin
      skid <= src;
    end
  end

  // Entry: differences and their magnitudes
  always_comb begin
    logic [32:0] d;
    p_next[ST_IN]    = '0;
    p_next[ST_IN].it = src;
    for (int i = 0; i < 3; i++) begin
      d = {src.b[i][31], src.b[i]} - {src.a[i][31], src.a[i]};
      p_next[ST_IN].dneg[i] = d[32];
      p_next[ST_IN].dm[i]   = d[32] ? (33'd0 - d) : d;
    end
  end

  // Square partial products
  always_comb begin
    p_next[ST_SQ_PART] = p[ST_SQ_PART-1];
    for (int i = 0; i < 3; i++) begin
      p_next[ST_SQ_PART].acc[i] =
        66'(p[ST_SQ_PART-1].dm[i] * p[ST_SQ_PART-1].dm[i][16:0]);
      p_next[ST_SQ_PART].hi[i] =
        49'(p[ST_SQ_PART-1].dm[i] * p[ST_SQ_PART-1].dm[i][32:17]);
    end
  end

  // Combine partial products into squares
  always_comb begin
    p_next[ST_SQ] = p[ST_SQ-1];
    for (int i = 0; i < 3; i++) begin
      p_next[ST_SQ].acc[i] = p[ST_SQ-1].acc[i] + (66'(p[ST_SQ-1].hi[i]) << 17);
    end
  end

  // Sum of squares, flag coincident particles
  always_comb begin
    p_next[ST_SUM]       = p[ST_SUM-1];
    p_next[ST_SUM].rad   = p[ST_SUM-1].acc[0] + p[ST_SUM-1].acc[1] + p[ST_SUM-1].acc[2];
    p_next[ST_SUM].degen = (p_next[ST_SUM].rad == 66'd0);
    p_next[ST_SUM].root  = '0;
  end

  // Square root, one bit per stage from the top
  for (genvar k = 0; k < RT_BITS; k++) begin : g_rt
    localparam int N   = ST_RT0 + k;
    localparam int BIT = RT_BITS - 1 - k;
    always_comb begin
      logic [66:0] trial;
      p_next[N] = p[N-1];
      trial = ({34'd0, p[N-1].root} << (BIT + 1)) | (67'd1 << (2 * BIT));
      if ({1'b0, p[N-1].rad} >= trial) begin
        p_next[N].rad  = 66'({1'b0, p[N-1].rad} - trial);
        p_next[N].root = p[N-1].root | (33'd1 << BIT);
      end
    end
  end

  // Excess length over the rest length
  always_comb begin
    logic [33:0] e;
    p_next[ST_EXC] = p[ST_EXC-1];
    e = {1'b0, p[ST_EXC-1].root} - {3'b000, p[ST_EXC-1].it.rest};
    p_next[ST_EXC].eneg = e[33];
    p_next[ST_EXC].em   = e[33] ? 33'(34'd0 - e) : e[32:0];
  end

  // Dividend partial products
  always_comb begin
    p_next[ST_PPART] = p[ST_PPART-1];
    for (int i = 0; i < 3; i++) begin
      p_next[ST_PPART].acc[i] =
        66'(p[ST_PPART-1].dm[i] * p[ST_PPART-1].em[16:0]);
      p_next[ST_PPART].hi[i] =
        49'(p[ST_PPART-1].dm[i] * p[ST_PPART-1].em[32:17]);
    end
  end

  // Combine into the dividend
  always_comb begin
    p_next[ST_PROD] = p[ST_PROD-1];
    for (int i = 0; i < 3; i++) begin
      p_next[ST_PROD].acc[i] = p[ST_PROD-1].acc[i] + (66'(p[ST_PROD-1].hi[i]) << 17);
      p_next[ST_PROD].quo[i] = '0;
    end
  end

  // Restoring division by the distance, one quotient bit per stage
  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    localparam int N   = ST_DIV0 + k;
    localparam int BIT = DIV_BITS - 1 - k;
    always_comb begin
      logic [32:0] rem_in;
      logic [33:0] r2;
      p_next[N] = p[N-1];
      for (int i = 0; i < 3; i++) begin
        rem_in = (k == 0) ? p[N-1].acc[i][65:33] : p[N-1].rem[i];
        r2     = {rem_in, p[N-1].acc[i][BIT]};
        if (r2 >= {1'b0, p[N-1].root}) begin
          p_next[N].rem[i]      = 33'(r2 - {1'b0, p[N-1].root});
          p_next[N].quo[i][BIT] = 1'b1;
        end else begin
          p_next[N].rem[i] = r2[32:0];
        end
      end
    end
  end

  // Advance the pipeline
  for (genvar n = 0; n <= ST_LAST; n++) begin : g_reg
    always_ff @(posedge clk) begin
      if (en) begin
        p[n] <= p_next[n];
      end
    end
  end

  // Advance the valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[ST_LAST-1:0], src_valid};
    end
  end

  // Apply shares, saturate
  always_comb begin
    logic [32:0] qa;
    logic [32:0] qb;
    logic [33:0] ca;
    logic [33:0] cb;
    logic        neg;
    logic        half;
    logic [34:0] sa;
    logic [34:0] sb;
    half = !p[ST_LAST].it.fa && !p[ST_LAST].it.fb;
    for (int i = 0; i < 3; i++) begin
      neg = p[ST_LAST].dneg[i] ^ p[ST_LAST].eneg;
      qa  = half ? (p[ST_LAST].quo[i] >> 1) : p[ST_LAST].quo[i];
      qb  = qa;
      ca  = neg ? (34'd0 - {1'b0, qa}) : {1'b0, qa};
      cb  = neg ? (34'd0 - {1'b0, qb}) : {1'b0, qb};
      sa  = {{3{p[ST_LAST].it.a[i][31]}}, p[ST_LAST].it.a[i]} + {ca[33], ca};
      sb  = {{3{p[ST_LAST].it.b[i][31]}}, p[ST_LAST].it.b[i]} - {cb[33], cb};
      res_data[32*i +: 32] = (p[ST_LAST].degen || p[ST_LAST].it.fa)
                             ? p[ST_LAST].it.a[i] : sat35(sa);
      res_data[96 + 32*i +: 32] = (p[ST_LAST].degen || p[ST_LAST].it.fb)
                                  ? p[ST_LAST].it.b[i] : sat35(sb);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= v[ST_LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata    <= res_data;
      m_tuser[0] <= p[ST_LAST].degen;
    end
  end

  `DCP_ASSERT_NEXT(a_skid_hold, clk, rst, skid_valid && !en, skid_valid)
  `DCP_ASSERT_NEXT(a_out_load, clk, rst, en && v[ST_LAST], m_tvalid)
  `DCP_ASSERT_NEXT(a_stage_hold, clk, rst, !en && v[ST_IN], v[ST_IN])

endmodule
